>>> hdl/kce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kce_pkg: shared types and constants for the keypad calculator evaluator
// Key codes, operator encodings, controller states and key decode helpers.
// ----------------------------------------------------------------------------
package kce_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned KEY_W   = 8;
    localparam int unsigned COUNT_W = 5;

    localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;
    localparam logic [KEY_W-1:0] KEY_MINUS = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_STAR  = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_SLASH = 8'h2F;
    localparam logic [KEY_W-1:0] KEY_EQUAL = 8'h3D;
    localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_FOLD,
        ST_EMIT
    } state_t;

    function automatic logic key_is_op(input logic [KEY_W-1:0] key);
        return (key == KEY_PLUS) || (key == KEY_MINUS) || (key == KEY_STAR) ||
               (key == KEY_SLASH) || (key == KEY_EQUAL);
    endfunction

    function automatic op_t key_to_op(input logic [KEY_W-1:0] key);
        op_t op;
        op = OP_ADD;
        unique case (key)
            KEY_MINUS: op = OP_SUB;
            KEY_STAR:  op = OP_MUL;
            KEY_SLASH: op = OP_DIV;
            default:   op = OP_ADD;
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

>>> hdl/keypad_calculator_evaluator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_calculator_evaluator_top: left-to-right four-function calculator
// Takes one key per beat, builds numbers and folds them into an accumulator
// with bit-serial add/subtract and iterative multiply/divide.
// ----------------------------------------------------------------------------
// One key is taken per input beat, one at a time. A digit key is accepted,
// then runs a bit-serial number*10+digit pass, one bit per cycle.
// An operator key only loads the accumulator when it is the first operator
// of an expression; else it folds: add and subtract run one bit per
// cycle through a single full adder, multiply makes one shift-add step per
// cycle, divide one restoring quotient bit per cycle, all 32 steps long. The
// '=' key folds the same way, then loads the output register, and waits there
// while a previous result has not been taken.
// Division by zero yields all ones and raises m_divided_by_zero on the result.
// Arithmetic is unsigned and wraps at 32 bits; '=' clears all state.
module keypad_calculator_evaluator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_key_code,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_result_value,
    output logic             m_divided_by_zero
);
    import kce_pkg::*;

    // control state
    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    op_t                 op_reg, op_next;
    op_t                 next_op_reg, next_op_next;
    logic                have_reg, have_next;
    logic                dz_reg, dz_next;
    logic                eq_reg, eq_next;
    logic                m_valid_reg, m_valid_next;

    // datapath
    logic [WORD_W-1:0]   acc_reg, acc_next;
    logic [WORD_W-1:0]   cur_reg, cur_next;
    logic [WORD_W-1:0]   work_reg, work_next;     // product or remainder
    logic [WORD_W-1:0]   dig_reg, dig_next;       // digit value, shifted out LSB first
    logic [2:0]          hist_reg, hist_next;     // last three bits of the old number
    logic [1:0]          carry_reg, carry_next;
    logic [WORD_W-1:0]   res_reg, res_next;
    logic                res_dz_reg, res_dz_next;

    logic                accept;
    logic                last_step;
    logic [2:0]          dsum;                    // n[i-1] + n[i-3] + d[i] + carry
    logic [1:0]          asum;
    logic                b_bit;
    logic [WORD_W-1:0]   prod_sum;
    logic [WORD_W:0]     rem_shift;
    logic [WORD_W+1:0]   rem_diff;
    logic                q_bit;
    logic [KEY_W-1:0]    dig_low;
    logic                dig_neg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign last_step = (count_reg == COUNT_W'(WORD_W - 1));

    // key - 48 taken as a 32-bit wrap: low byte plus sign fill
    assign dig_low = s_key_code - KEY_ZERO;
    assign dig_neg = (s_key_code < KEY_ZERO);

    // digit pass: new = (n<<3) + (n<<1) + d, one bit per cycle
    assign dsum = 3'(hist_reg[0]) + 3'(hist_reg[2]) + 3'(dig_reg[0]) + 3'(carry_reg);

    // add/subtract bit slice
    assign b_bit = (op_reg == OP_SUB) ? ~cur_reg[0] : cur_reg[0];
    assign asum  = 2'(acc_reg[0]) + 2'(b_bit) + 2'(carry_reg[0]);

    // shift-add multiply step
    assign prod_sum = work_reg + (cur_reg[0] ? acc_reg : '0);

    // restoring divide step
    assign rem_shift = {work_reg, acc_reg[WORD_W-1]};
    assign rem_diff  = {1'b0, rem_shift} - {2'b00, cur_reg};
    assign q_bit     = ~rem_diff[WORD_W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            op_reg      <= OP_ADD;
            next_op_reg <= OP_ADD;
            have_reg    <= 1'b0;
            dz_reg      <= 1'b0;
            eq_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            cur_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            op_reg      <= op_next;
            next_op_reg <= next_op_next;
            have_reg    <= have_next;
            dz_reg      <= dz_next;
            eq_reg      <= eq_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            cur_reg     <= cur_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg   <= work_next;
        dig_reg    <= dig_next;
        hist_reg   <= hist_next;
        carry_reg  <= carry_next;
        res_reg    <= res_next;
        res_dz_reg <= res_dz_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        op_next      = op_reg;
        next_op_next = next_op_reg;
        have_next    = have_reg;
        dz_next      = dz_reg;
        eq_next      = eq_reg;
        m_valid_next = m_valid_reg;
        acc_next     = acc_reg;
        cur_next     = cur_reg;
        work_next    = work_reg;
        dig_next     = dig_reg;
        hist_next    = hist_reg;
        carry_next   = carry_reg;
        res_next     = res_reg;
        res_dz_next  = res_dz_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    count_next = '0;
                    if (key_is_op(s_key_code)) begin
                        eq_next      = (s_key_code == KEY_EQUAL);
                        next_op_next = key_to_op(s_key_code);
                        if (have_reg) begin
                            work_next  = '0;
                            carry_next = (op_reg == OP_SUB) ? 2'd1 : 2'd0;
                            if (op_reg == OP_DIV && cur_reg == '0) begin
                                dz_next = 1'b1;
                            end
                            state_next = ST_FOLD;
                        end else begin
                            // first operator just loads the accumulator
                            acc_next  = cur_reg;
                            cur_next  = '0;
                            have_next = 1'b1;
                            if (s_key_code == KEY_EQUAL) begin
                                state_next = ST_EMIT;
                            end else begin
                                op_next = key_to_op(s_key_code);
                            end
                        end
                    end else begin
                        dig_next   = {{(WORD_W-KEY_W){dig_neg}}, dig_low};
                        hist_next  = '0;
                        carry_next = '0;
                        state_next = ST_DIGIT;
                    end
                end
            end

            ST_DIGIT: begin
                cur_next   = {dsum[0], cur_reg[WORD_W-1:1]};
                hist_next  = {hist_reg[1:0], cur_reg[0]};
                carry_next = dsum[2:1];
                dig_next   = {1'b0, dig_reg[WORD_W-1:1]};
                count_next = count_reg + 1'b1;
                if (last_step) begin
                    state_next = ST_IDLE;
                end
            end

            ST_FOLD: begin
                count_next = count_reg + 1'b1;
                unique case (op_reg)
                    OP_ADD, OP_SUB: begin
                        acc_next   = {asum[0], acc_reg[WORD_W-1:1]};
                        cur_next   = {1'b0, cur_reg[WORD_W-1:1]};
                        carry_next = {1'b0, asum[1]};
                    end
                    OP_MUL: begin
                        work_next = prod_sum;
                        acc_next  = last_step ? prod_sum : {acc_reg[WORD_W-2:0], 1'b0};
                        cur_next  = {1'b0, cur_reg[WORD_W-1:1]};
                    end
                    OP_DIV: begin
                        work_next = q_bit ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
                        acc_next  = {acc_reg[WORD_W-2:0], q_bit};
                        if (last_step) begin
                            cur_next = '0;
                        end
                    end
                    default: ;
                endcase
                if (last_step) begin
                    have_next = 1'b1;
                    if (eq_reg) begin
                        state_next = ST_EMIT;
                    end else begin
                        op_next    = next_op_reg;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    res_next     = acc_reg;
                    res_dz_next  = dz_reg;
                    m_valid_next = 1'b1;
                    acc_next     = '0;
                    cur_next     = '0;
                    op_next      = OP_ADD;
                    have_next    = 1'b0;
                    dz_next      = 1'b0;
                    eq_next      = 1'b0;
                    state_next   = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid           = m_valid_reg;
    assign m_result_value    = res_reg;
    assign m_divided_by_zero = res_dz_reg;

    // a result beat only appears out of the emit step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result valid raised outside emit");

    // a fold always leaves the current number cleared and an operand held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD && last_step) |=> (cur_reg == '0 && have_reg))
        else $error("fold did not clear current number");

    // the step counter is back at zero whenever a serial pass ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DIGIT || state_reg == ST_FOLD) && last_step) |=> count_reg == '0)
        else $error("step counter out of sync");

    // emit never overwrites a result that has not been taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> ($stable(res_reg) && $stable(res_dz_reg)))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

>>> verif/keypad_calculator_evaluator_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keypad_calculator_evaluator_top_tb: self-checking bench for the calculator
// Streams keypad bytes into the evaluator, predicts every '=' result with a
// local left-to-right calculator and checks each output beat in order.
// ----------------------------------------------------------------------------
module keypad_calculator_evaluator_top_tb;

    import kce_pkg::*;

    // ~850 random keys after the directed opener
    localparam int unsigned RANDOM_KEYS = 850;
    // no handshake on either side for this long means the block is hung;
    // worst correct stretch is a long gap plus a key plus a long output stall,
    // so this leaves plenty of room
    localparam int unsigned STALL_LIMIT = 4000;
    // '=' folds and then emits before its beat shows up
    localparam int unsigned DRAIN_TAIL  = 100;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        logic [KEY_W-1:0] key;
        bit               hold;     // wait for all results before sending
    } press_t;

    typedef struct {
        logic [WORD_W-1:0] value;
        logic              div0;
    } total_t;

    logic               aclk              = 1'b0;
    logic               aresetn           = 1'b0;
    logic               s_valid           = 1'b0;
    logic               s_ready;
    logic [KEY_W-1:0]   s_key_code        = '0;
    logic               m_valid;
    logic               m_ready           = 1'b0;
    logic [WORD_W-1:0]  m_result_value;
    logic               m_divided_by_zero;

    keypad_calculator_evaluator_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_key_code        (s_key_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_value    (m_result_value),
        .m_divided_by_zero (m_divided_by_zero)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Keys waiting to be sent and totals waiting to come back
    press_t      key_presses[$];
    total_t      expected_totals[$];
    int unsigned keys_queued = 0;
    int unsigned keys_taken  = 0;
    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    bit          timed_out   = 1'b0;

    // ------------------------------------------------------------------------
    // Calculator state as the block should hold it
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0] calc_acc    = '0;
    logic [WORD_W-1:0] calc_entry  = '0;   // number being typed
    op_t               calc_op     = OP_ADD;
    logic              calc_loaded = 1'b0; // accumulator holds a first operand
    logic              calc_div0   = 1'b0;

    // Apply one accepted key; '=' pushes the total it produces.
    task automatic press_key(input logic [KEY_W-1:0] key);
        op_t next_op;
        bit  is_op;
        is_op   = 1'b1;
        next_op = OP_ADD;
        case (key)
            KEY_PLUS:  next_op = OP_ADD;
            KEY_MINUS: next_op = OP_SUB;
            KEY_STAR:  next_op = OP_MUL;
            KEY_SLASH: next_op = OP_DIV;
            KEY_EQUAL: next_op = OP_ADD;
            default:   is_op   = 1'b0;
        endcase
        if (!is_op) begin
            // anything that is not an operator is a digit, even letters and
            // control bytes; byte minus '0' wraps for codes below '0'
            calc_entry = calc_entry * 32'd10 + 32'(key) - 32'(KEY_ZERO);
            return;
        end
        // fold the typed number in; the first operator only loads it
        if (!calc_loaded) begin
            calc_acc = calc_entry;
        end else begin
            case (calc_op)
                OP_ADD: calc_acc = calc_acc + calc_entry;
                OP_SUB: calc_acc = calc_acc - calc_entry;
                OP_MUL: calc_acc = calc_acc * calc_entry;
                OP_DIV: begin
                    if (calc_entry == '0) begin
                        calc_acc  = '1;
                        calc_div0 = 1'b1;
                    end else begin
                        calc_acc = calc_acc / calc_entry;
                    end
                end
            endcase
        end
        calc_loaded = 1'b1;
        calc_entry  = '0;
        calc_op     = next_op;
        if (key == KEY_EQUAL) begin
            expected_totals.push_back('{value: calc_acc, div0: calc_div0});
            calc_acc    = '0;
            calc_op     = OP_ADD;
            calc_loaded = 1'b0;
            calc_div0   = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_press(input logic [KEY_W-1:0] key, input bit hold);
        key_presses.push_back('{key: key, hold: hold});
        keys_queued++;
    endtask

    task automatic add_text(input string keys);
        for (int i = 0; i < keys.len(); i++) begin
            add_press(keys[i], 1'b0);
        end
    endtask

    function automatic logic [KEY_W-1:0] random_op_key();
        case ($urandom_range(0, 3))
            0:       return KEY_PLUS;
            1:       return KEY_MINUS;
            2:       return KEY_STAR;
            default: return KEY_SLASH;
        endcase
    endfunction

    // Mostly short gaps, some medium, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return $urandom_range(0, 2);
        if (roll < 95) return $urandom_range(3, 12);
        return $urandom_range(40, 200);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one key per beat, random gaps between beats. A key marked hold
    // is kept back until every outstanding total has been seen. The model is
    // stepped at the edge where the beat is taken.
    // ------------------------------------------------------------------------
    int unsigned send_gap    = 0;
    bit          send_steady = 1'b0;   // back-to-back stretch, no gaps

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                press_key(s_key_code);
                keys_taken <= keys_taken + 1;
                if ($urandom_range(0, 39) == 0) begin
                    send_steady <= !send_steady;
                end
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (key_presses.size() != 0 &&
                             !(key_presses[0].hold && expected_totals.size() != 0)) begin
                    s_valid    <= 1'b1;
                    s_key_code <= key_presses[0].key;
                    void'(key_presses.pop_front());
                    send_gap   <= send_steady ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each result beat against the oldest predicted total and
    // throttles m_ready with random stalls.
    // ------------------------------------------------------------------------
    int unsigned sink_stall  = 0;
    bit          sink_steady = 1'b0;   // ready held high for a while

    always @(posedge aclk) begin
        total_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            sink_stall <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_totals.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: result beat with nothing expected: value %h div0 %b",
                                 $realtime, m_result_value, m_divided_by_zero);
                    end
                    mismatches++;
                end else begin
                    want = expected_totals.pop_front();
                    if (m_result_value !== want.value || m_divided_by_zero !== want.div0) begin
                        if (mismatches < MAX_REPORTS) begin
                            $display("%0t: result mismatch: value exp %h got %h, div0 exp %b got %b",
                                     $realtime, want.value, m_result_value,
                                     want.div0, m_divided_by_zero);
                        end
                        mismatches++;
                    end
                end
                if ($urandom_range(0, 19) == 0) begin
                    sink_steady <= !sink_steady;
                end
            end
            if (sink_stall != 0) begin
                sink_stall <= sink_stall - 1;
                m_ready    <= 1'b0;
            end else if (!sink_steady && $urandom_range(0, 7) == 0) begin
                sink_stall <= pick_gap();
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            timed_out <= 1'b1;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus build, reset and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned      operands;
        int unsigned      digits;
        int unsigned      roll;
        bit               hold;
        bit               first_random;
        logic [KEY_W-1:0] op_key;

        // Directed opener
        add_text("=");                  // equals alone
        add_text("7=");                 // equals as first operator
        add_press(8'hFF, 1'b0);         // non-digit bytes, all bits high/low
        add_press(8'h00, 1'b0);
        add_text("A=");
        add_text("+=");                 // empty numbers on both sides
        add_text("9/0=");               // divide by zero
        add_text("5-8*3=");             // subtract wraps below zero
        add_text("/5=");                // empty first operand
        add_text("8/=");                // zero divisor completed by '='

        // Random expressions, mostly well formed
        first_random = 1'b1;
        while (keys_queued < 25 + RANDOM_KEYS) begin
            // first random expression always waits for the opener to drain
            hold         = first_random || ($urandom_range(0, 19) == 0);
            first_random = 1'b0;
            if ($urandom_range(0, 6) == 0) begin
                // noise: any bytes, operators over-weighted, then '='
                repeat ($urandom_range(1, 8)) begin
                    if ($urandom_range(0, 9) < 4) begin
                        add_press(random_op_key(), hold);
                    end else begin
                        add_press(8'($urandom_range(0, 255)), hold);
                    end
                    hold = 1'b0;
                end
            end else begin
                operands = $urandom_range(1, 5);
                op_key   = KEY_PLUS;
                for (int k = 0; k < operands; k++) begin
                    if (k != 0) begin
                        op_key = random_op_key();
                        add_press(op_key, hold);
                        hold = 1'b0;
                    end
                    roll = $urandom_range(0, 99);
                    if (k != 0 && op_key == KEY_SLASH && roll < 15) begin
                        add_press(KEY_ZERO, hold);      // divisor of zero
                        hold = 1'b0;
                        continue;
                    end
                    if (roll < 20) digits = 0;          // empty number
                    else if (roll < 30) digits = $urandom_range(10, 14); // wraps
                    else digits = $urandom_range(1, 4);
                    repeat (digits) begin
                        if ($urandom_range(0, 19) == 0) begin
                            add_press(8'($urandom_range(0, 255)), hold);
                        end else begin
                            add_press(KEY_ZERO + 8'($urandom_range(0, 9)), hold);
                        end
                        hold = 1'b0;
                    end
                end
            end
            add_press(KEY_EQUAL, hold);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (!timed_out && (keys_taken < keys_queued || expected_totals.size() != 0)) begin
            @(posedge aclk);
        end
        // catch stray beats after the last expected one
        if (!timed_out) begin
            repeat (DRAIN_TAIL) @(posedge aclk);
        end

        if (!timed_out && mismatches == 0 && expected_totals.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
